@@ design/sorted_callout_timer_queue_defines.svh @@
// Assertion macros shared by the checker
`ifndef SORTED_CALLOUT_TIMER_QUEUE_DEFINES_SVH
`define SORTED_CALLOUT_TIMER_QUEUE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SCTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SCTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sctq_pkg.sv @@
`timescale 1ns / 1ps
package sctq_pkg;
    localparam int QueueDepth = 16;
    localparam int CntW = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        OP_SCHED  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_SCHED  = 3'd0,
        K_CANCEL = 3'd1,
        K_FIRED  = 3'd2,
        K_DONE   = 3'd3,
        K_FULL   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_EXPIRE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] time_v;
        logic [31:0] id;
        logic [31:0] handle;
    } t_entry;

    // Per-cell command broadcast from the controller
    typedef enum logic [1:0] {
        C_HOLD,
        C_INSERT,
        C_REMOVE
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        t_entry      ins;
        logic [31:0] key;
    } t_cell_ctl;
endpackage

@@ design/sctq_cell.sv @@
`timescale 1ns / 1ps
module sctq_cell
    import sctq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,      // this slot is below entry_count
    input  t_entry    i_left,       // entry of the slot below
    input  logic      i_left_hit,   // slot below is at or above the insert point (insert only)
    input  t_entry    i_right,      // entry of the slot above
    input  logic      i_right_hit,
    output t_entry    o_entry,
    output logic      o_time_hit,   // stored time >= key (or invalid)
    output logic      o_id_hit      // stored id == key and valid
);
    t_entry r_entry;
    t_entry n_entry;

    // Local compares, registered by the controller as a hit vector
    assign o_time_hit = !i_valid || (r_entry.time_v >= i_ctl.key);
    assign o_id_hit   = i_valid && (r_entry.id == i_ctl.key);
    assign o_entry    = r_entry;

    // Shift or load depending on where the hit boundary is
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            C_INSERT: begin
                if (i_left_hit)      n_entry = i_left;
                else if (i_right_hit) n_entry = i_ctl.ins;
            end
            C_REMOVE: begin
                if (i_right_hit) n_entry = i_right;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

@@ design/sorted_callout_timer_queue.sv @@
// Each request is captured in the idle state; the match state registers the hit
// vector and the update state registers the schedule or cancel result. Expire
// runs from the expire state and gives one result per cycle for each due entry
// while i_ready keeps up, then the done result. One request at a time.
// The chain of slot cells compares and shifts all slots in parallel.
// Reset (synchronous, active low) empties the table and clears the id counter.
`timescale 1ns / 1ps
module sorted_callout_timer_queue
    import sctq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_now_secs,
    input  logic [31:0] i_delay_secs,
    input  logic [31:0] i_handle,
    input  logic [31:0] i_cancel_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_timer_id,
    output logic [31:0] o_fired_handle,
    output logic        o_found,
    output logic [31:0] o_wait_secs,
    output logic        o_last
);
    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [31:0] r_idc, n_idc;
    t_op r_op;
    logic [31:0] r_key, r_now, r_hnd;
    logic [QueueDepth-1:0] r_hit;
    logic [QueueDepth-1:0] w_time_hit, w_id_hit, w_valid, w_first, w_mask;
    t_entry w_ent [QueueDepth];
    t_cell_ctl w_ctl;
    logic r_ov, n_ov;
    logic [2:0] r_kind, n_kind;
    logic [31:0] r_cid, n_cid, r_fh, n_fh, r_ws, n_ws;
    logic r_fnd, n_fnd, r_lst, n_lst;
    logic w_any;

    // Slot valid bits from the fill count
    always_comb begin
        for (int i = 0; i < QueueDepth; i++) begin
            w_valid[i] = (CntW'(i) < r_count);
        end
    end

    // Lowest set hit, then mask of that slot and all above
    always_comb begin
        w_first = r_hit & (~r_hit + QueueDepth'(1));
        w_mask  = ~(w_first - QueueDepth'(1));
        w_any   = |r_hit;
    end

    // Cell row
    for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
        t_entry w_l, w_r;
        logic w_lh, w_rh;
        if (g == 0) begin : g_lo
            assign w_l  = '0;
            assign w_lh = 1'b0;
        end else begin : g_lo
            assign w_l  = w_ent[g-1];
            assign w_lh = (w_ctl.cmd == C_INSERT) ? w_mask[g-1] : 1'b0;
        end
        if (g == QueueDepth - 1) begin : g_hi
            assign w_r = '0;
        end else begin : g_hi
            assign w_r = w_ent[g+1];
        end
        // Insert: own hit is the first masked slot; remove: own slot at/above match
        assign w_rh = (w_ctl.cmd == C_INSERT) ? w_first[g] : w_mask[g];
        sctq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (w_valid[g]),
            .i_left     (w_l),
            .i_left_hit (w_lh),
            .i_right    (w_r),
            .i_right_hit(w_rh),
            .o_entry    (w_ent[g]),
            .o_time_hit (w_time_hit[g]),
            .o_id_hit   (w_id_hit[g])
        );
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_timer_id     = r_cid;
    assign o_fired_handle = r_fh;
    assign o_found        = r_fnd;
    assign o_wait_secs    = r_ws;
    assign o_last         = r_lst;

    // Controller
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idc   = r_idc;
        n_ov    = r_ov && !i_ready;
        n_kind  = r_kind;
        n_cid   = r_cid;
        n_fh    = r_fh;
        n_fnd   = r_fnd;
        n_ws    = r_ws;
        n_lst   = r_lst;
        w_ctl.cmd = C_HOLD;
        w_ctl.key = r_key;
        w_ctl.ins.time_v = r_key;
        w_ctl.ins.id     = (r_idc == 32'hFFFF_FFFF) ? 32'd1 : r_idc + 32'd1;
        w_ctl.ins.handle = r_hnd;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_MATCH;
            end
            S_MATCH: n_state = S_UPDATE;
            S_UPDATE: begin
                n_kind = K_CANCEL; n_cid = '0; n_fh = '0; n_fnd = 1'b0;
                n_ws = '0; n_lst = 1'b1;
                if (r_op == OP_SCHED) begin
                    if (r_count >= CntW'(QueueDepth)) begin
                        n_kind = K_FULL;
                    end else begin
                        w_ctl.cmd = C_INSERT;
                        n_kind  = K_SCHED;
                        n_cid   = w_ctl.ins.id;
                        n_idc   = w_ctl.ins.id;
                        n_count = r_count + CntW'(1);
                    end
                    n_ov = 1'b1; n_state = S_OUT;
                end else if (r_op == OP_CANCEL) begin
                    if (w_any) begin
                        w_ctl.cmd = C_REMOVE;
                        n_count = r_count - CntW'(1);
                    end
                    n_fnd = w_any;
                    n_ov = 1'b1; n_state = S_OUT;
                end else if (r_op == OP_EXPIRE) begin
                    n_state = S_EXPIRE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXPIRE: begin
                if (!r_ov || i_ready) begin
                    n_cid = '0; n_fh = '0; n_fnd = 1'b0; n_ws = '0;
                    if (r_count != '0 && w_ent[0].time_v <= r_now) begin
                        n_kind = K_FIRED; n_lst = 1'b0;
                        n_cid = w_ent[0].id; n_fh = w_ent[0].handle;
                        w_ctl.cmd = C_REMOVE;
                        w_ctl.key = '0;
                        n_count = r_count - CntW'(1);
                    end else begin
                        n_kind = K_DONE; n_lst = 1'b1;
                        if (r_count != '0) n_ws = w_ent[0].time_v - r_now;
                        n_state = S_OUT;
                    end
                    n_ov = 1'b1;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Slot 0 removal during expiry uses the full mask
    logic [QueueDepth-1:0] w_hit_next;
    always_comb begin
        w_hit_next = r_hit;
        if (r_state == S_MATCH) begin
            w_hit_next = (r_op == OP_SCHED) ? w_time_hit : w_id_hit;
        end else if (r_state == S_UPDATE && r_op == OP_EXPIRE) begin
            w_hit_next = QueueDepth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idc   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idc   <= n_idc;
            r_ov    <= n_ov;
        end
    end

    // Request capture and payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op  <= t_op'(i_operation);
            r_now <= i_now_secs;
            r_hnd <= i_handle;
            r_key <= (t_op'(i_operation) == OP_SCHED) ? i_now_secs + i_delay_secs
                                                      : i_cancel_id;
        end
        r_hit  <= w_hit_next;
        r_kind <= n_kind;
        r_cid  <= n_cid;
        r_fh   <= n_fh;
        r_fnd  <= n_fnd;
        r_ws   <= n_ws;
        r_lst  <= n_lst;
    end
endmodule

@@ design/sctq_checker.sv @@
`timescale 1ns / 1ps
`include "sorted_callout_timer_queue_defines.svh"
module sctq_checker
    import sctq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_kind,
    input logic [31:0] o_timer_id,
    input logic        o_last
);
    `SCTQ_ASSERT_IMP(a_sched_id_nz, i_clk, i_rst_n, o_valid && o_kind == K_SCHED, o_timer_id != 32'd0, "scheduled id is zero")
    `SCTQ_ASSERT_IMP(a_fired_not_last, i_clk, i_rst_n, o_valid && o_kind == K_FIRED, !o_last, "expired entry marked last")
    `SCTQ_ASSERT_IMP(a_busy_no_ready, i_clk, i_rst_n, o_valid, !o_ready, "new request taken during results")
    `SCTQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kind), "result dropped")
endmodule

bind sorted_callout_timer_queue sctq_checker u_sctq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_kind      (o_kind),
    .o_timer_id  (o_timer_id),
    .o_last      (o_last)
);
